@@ hw/rtl/sese_pkg.sv @@
// shared types, widths and codes for the s-curve edge start estimator
// no dependencies; imported by every module of the block but sese_ram
`default_nettype none

package sese_pkg;

    localparam int DEF_MAX_POINTS = 256;

    localparam int COL_W     = 9;
    localparam int ADR_W     = 10;
    localparam int AMP_W     = 8;
    localparam int HIT_W     = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int START_W   = 17;
    localparam int STATUS_W  = 2;
    localparam int POINT_W   = 9;
    localparam int CHG_W     = AMP_W + CFG_W;
    localparam int WORD_W    = HIT_W + AMP_W;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EPS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INJ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd3;

    localparam logic [CFG_W-1:0] RST_EPS    = 8'd7;
    localparam logic [CFG_W-1:0] RST_INJ    = 8'd50;
    localparam logic [CFG_W-1:0] RST_TOP    = 8'd89;
    localparam logic [CFG_W-1:0] RST_BOTTOM = 8'd0;

    typedef enum logic [STATUS_W-1:0] {
        PIX_NORMAL = 2'd0,
        PIX_HOT    = 2'd1,
        PIX_DEAD   = 2'd2
    } pix_status_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic init;
        logic step;
        logic mul;
        logic fin;
    } sese_cmd_t;

    typedef struct packed {
        logic need_finish;
        logic one_point;
        logic scan_end;
        logic out_full;
    } sese_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/scurve_edge_start_estimator.sv @@
// top level of the s-curve edge start estimator
// depends on sese_pkg, sese_ctrl, sese_datapath (which holds two sese_ram)
//
//   channel   signals                                   direction
//   in        in_valid / in_stall, point fields         request into the block
//   out       out_valid / out_stall, result fields      request out of the block
//   cfg       cfg_write, cfg_index, cfg_data            register writes, no read-back
//
// a request that stays on the current pixel is taken and written to the stores while they
// have room; a request that closes a pixel runs load and init to prime the store reads, scan
// steps that each take one point of both parallel edge scans, a multiply step and a result
// step; the scans end early once both edges are found
// rst_n clears the sequencer, point count, pixel identity and result valid; stores need no clear
// out_stall holds the result register; points for the same pixel are still taken meanwhile
`default_nettype none

module scurve_edge_start_estimator
    import sese_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 operation,
    input  wire logic [COL_W-1:0]     pixel_column,
    input  wire logic [ADR_W-1:0]     pixel_address,
    input  wire logic [AMP_W-1:0]     amplitude,
    input  wire logic [HIT_W-1:0]     hit_count,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [COL_W-1:0]     out_column,
    output logic      [ADR_W-1:0]     out_address,
    output logic      [START_W-1:0]   start_half_electrons,
    output logic      [STATUS_W-1:0]  pixel_status,
    output logic                      full_not_reached,
    output logic                      zero_not_seen,
    output logic      [POINT_W-1:0]   point_total,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    sese_cmd_t  cmd;
    sese_stat_t stat;

    sese_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sese_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .operation            (operation),
        .pixel_column         (pixel_column),
        .pixel_address        (pixel_address),
        .amplitude            (amplitude),
        .hit_count            (hit_count),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .out_column           (out_column),
        .out_address          (out_address),
        .start_half_electrons (start_half_electrons),
        .pixel_status         (pixel_status),
        .full_not_reached     (full_not_reached),
        .zero_not_seen        (zero_not_seen),
        .point_total          (point_total)
    );

    // result is only written into an empty result register
    a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> !out_valid)
        else $error("result written while previous result pending");

    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.fin))
        else $error("result valid without a finish cycle");

    a_load_then_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.init)
        else $error("store read not followed by scan setup");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !(cmd.load || cmd.init || cmd.step || cmd.mul || cmd.fin))
        else $error("request taken while a pixel is being finished");

endmodule

`default_nettype wire

@@ hw/rtl/sese_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module sese_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sese_ctrl.sv @@
// sequencer for the estimator: idle, load, init, scan, multiply, finish
// depends on sese_pkg for command and status structs
`default_nettype none

module sese_ctrl
    import sese_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire sese_stat_t stat,
    output sese_cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_INIT = 6'b000100,
        S_SCAN = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // a request that closes a pixel waits until the result register is free
    assign in_stall = (state_reg != S_IDLE) || (stat.out_full && stat.need_finish);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.need_finish)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = stat.one_point ? S_MUL : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sese_datapath.sv @@
// point stores, edge scan registers, charge multipliers and result register
// depends on sese_pkg and sese_ram
`default_nettype none

module sese_datapath
    import sese_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sese_cmd_t            cmd,
    output sese_stat_t                stat,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 operation,
    input  wire logic [COL_W-1:0]     pixel_column,
    input  wire logic [ADR_W-1:0]     pixel_address,
    input  wire logic [AMP_W-1:0]     amplitude,
    input  wire logic [HIT_W-1:0]     hit_count,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [COL_W-1:0]     out_column,
    output logic      [ADR_W-1:0]     out_address,
    output logic      [START_W-1:0]   start_half_electrons,
    output logic      [STATUS_W-1:0]  pixel_status,
    output logic                      full_not_reached,
    output logic                      zero_not_seen,
    output logic      [POINT_W-1:0]   point_total
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    // configuration and pixel bookkeeping
    logic [CFG_W-1:0]  eps_reg;
    logic [CFG_W-1:0]  inj_reg;
    logic [CFG_W-1:0]  top_reg;
    logic [CFG_W-1:0]  bottom_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [COL_W-1:0]  prev_col_reg;
    logic [ADR_W-1:0]  prev_addr_reg;

    // request that closed a pixel, written after the scan
    logic              pend_op_reg;
    logic [COL_W-1:0]  pend_col_reg;
    logic [ADR_W-1:0]  pend_addr_reg;
    logic [AMP_W-1:0]  pend_amp_reg;
    logic [HIT_W-1:0]  pend_hit_reg;

    // scan state: dn walks down from the top point, up walks up from the bottom
    logic [ADDR_W-1:0] pa_reg;
    logic [ADDR_W-1:0] pb_reg;
    logic [ADDR_W-1:0] rem_reg;
    logic [HIT_W-1:0]  dn_run_reg;
    logic [HIT_W-1:0]  up_run_reg;
    logic [AMP_W-1:0]  dn_amp_reg;
    logic [AMP_W-1:0]  up_amp_reg;
    logic [AMP_W-1:0]  top_amp_reg;
    logic [AMP_W-1:0]  bot_amp_reg;
    logic [HIT_W-1:0]  bot_hit_reg;
    logic              dn_done_reg;
    logic              up_done_reg;
    logic              no_full_reg;
    logic              no_zero_reg;

    // charges
    logic [CHG_W-1:0]   upper_q_reg;
    logic [CHG_W-1:0]   lower_q_reg;
    logic [CHG_W-1:0]   top_q_reg;
    logic [CHG_W-1:0]   bot_q_reg;
    logic [START_W-1:0] fb_q_reg;

    // result register
    logic               out_valid_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ADR_W-1:0]   out_addr_reg;
    logic [START_W-1:0] start_reg;
    pix_status_t        status_reg;
    logic               nf_reg;
    logic               nz_reg;
    logic [POINT_W-1:0] pt_reg;

    logic [CNT_W-1:0]   cnt_m1;
    logic [ADDR_W-1:0]  last_idx;
    logic               has_room;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [WORD_W-1:0]  rd_data_a;
    logic [WORD_W-1:0]  rd_data_b;
    logic [HIT_W-1:0]   a_hit;
    logic [AMP_W-1:0]   a_amp;
    logic [HIT_W-1:0]   b_hit;
    logic [AMP_W-1:0]   b_amp;
    logic               dn_brk;
    logic               up_brk;
    logic               edge_at_end;
    pix_status_t        status_next;
    logic [START_W-1:0] start_next;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign last_idx = cnt_m1[ADDR_W-1:0];
    assign has_room = count_reg < CNT_W'(MAX_POINTS);

    assign stat.need_finish = (count_reg != '0)
                              && ((operation == OP_FLUSH)
                                  || (pixel_column != prev_col_reg)
                                  || (pixel_address != prev_addr_reg));
    assign stat.one_point   = (count_reg == CNT_W'(1));
    assign stat.out_full    = out_valid_reg;

    // both stores hold the same words so the two scans read in parallel
    assign wr_en   = (cmd.accept && !stat.need_finish && (operation == OP_POINT) && has_room)
                     || (cmd.fin && (pend_op_reg == OP_POINT));
    assign wr_addr = cmd.fin ? '0 : count_reg[ADDR_W-1:0];
    assign wr_data = cmd.fin ? {pend_hit_reg, pend_amp_reg} : {hit_count, amplitude};

    assign rd_addr_a = cmd.load ? last_idx : pa_reg;
    assign rd_addr_b = cmd.load ? '0 : pb_reg;

    sese_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_ram_dn (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    sese_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_ram_up (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    assign a_hit = rd_data_a[WORD_W-1:AMP_W];
    assign a_amp = rd_data_a[AMP_W-1:0];
    assign b_hit = rd_data_b[WORD_W-1:AMP_W];
    assign b_amp = rd_data_b[AMP_W-1:0];

    assign dn_brk = !dn_done_reg && (dn_run_reg > a_hit);
    assign up_brk = !up_done_reg && (up_run_reg < b_hit);

    assign stat.scan_end = (rem_reg == ADDR_W'(1))
                           || ((dn_done_reg || dn_brk) && (up_done_reg || up_brk));

    // hot or dead only when one edge still sits on its end point
    always_comb
    begin
        edge_at_end = (upper_q_reg == top_q_reg) || (lower_q_reg == bot_q_reg);
        status_next = PIX_NORMAL;
        if (edge_at_end)
        begin
            if (bot_hit_reg == inj_reg)
            begin
                status_next = PIX_HOT;
            end
            else if (bot_hit_reg == '0)
            begin
                status_next = PIX_DEAD;
            end
        end
        if (status_next != PIX_NORMAL)
        begin
            start_next = fb_q_reg;
        end
        else
        begin
            start_next = START_W'(upper_q_reg) + START_W'(lower_q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg       <= RST_EPS;
            inj_reg       <= RST_INJ;
            top_reg       <= RST_TOP;
            bottom_reg    <= RST_BOTTOM;
            count_reg     <= '0;
            prev_col_reg  <= '0;
            prev_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_EPS:    eps_reg    <= cfg_data;
                    CFG_INJ:    inj_reg    <= cfg_data;
                    CFG_TOP:    top_reg    <= cfg_data;
                    CFG_BOTTOM: bottom_reg <= cfg_data;
                endcase
            end

            if (cmd.accept && !stat.need_finish && (operation == OP_POINT))
            begin
                prev_col_reg  <= pixel_column;
                prev_addr_reg <= pixel_address;
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (cmd.fin)
            begin
                if (pend_op_reg == OP_POINT)
                begin
                    prev_col_reg  <= pend_col_reg;
                    prev_addr_reg <= pend_addr_reg;
                    count_reg     <= CNT_W'(1);
                end
                else
                begin
                    count_reg <= '0;
                end
            end

            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_op_reg   <= operation;
            pend_col_reg  <= pixel_column;
            pend_addr_reg <= pixel_address;
            pend_amp_reg  <= amplitude;
            pend_hit_reg  <= hit_count;
        end

        if (cmd.load)
        begin
            pa_reg <= last_idx - ADDR_W'(1);
            pb_reg <= ADDR_W'(1);
        end
        else if (cmd.init || cmd.step)
        begin
            pa_reg <= pa_reg - ADDR_W'(1);
            pb_reg <= pb_reg + ADDR_W'(1);
        end

        if (cmd.init)
        begin
            dn_run_reg  <= a_hit;
            top_amp_reg <= a_amp;
            dn_amp_reg  <= a_amp;
            up_run_reg  <= b_hit;
            bot_amp_reg <= b_amp;
            up_amp_reg  <= b_amp;
            bot_hit_reg <= b_hit;
            dn_done_reg <= 1'b0;
            up_done_reg <= 1'b0;
            no_full_reg <= 1'b1;
            no_zero_reg <= 1'b1;
            rem_reg     <= last_idx;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_reg - ADDR_W'(1);
            // running value is tested before the step compare
            if (!dn_done_reg)
            begin
                if (dn_run_reg == inj_reg)
                begin
                    no_full_reg <= 1'b0;
                end
                if (dn_brk)
                begin
                    dn_amp_reg  <= a_amp;
                    dn_done_reg <= 1'b1;
                end
                else
                begin
                    dn_run_reg <= a_hit;
                end
            end
            if (!up_done_reg)
            begin
                if (up_run_reg == '0)
                begin
                    no_zero_reg <= 1'b0;
                end
                if (up_brk)
                begin
                    up_amp_reg  <= b_amp;
                    up_done_reg <= 1'b1;
                end
                else
                begin
                    up_run_reg <= b_hit;
                end
            end
        end

        if (cmd.mul)
        begin
            upper_q_reg <= CHG_W'(dn_amp_reg) * CHG_W'(eps_reg);
            lower_q_reg <= CHG_W'(up_amp_reg) * CHG_W'(eps_reg);
            top_q_reg   <= CHG_W'(top_amp_reg) * CHG_W'(eps_reg);
            bot_q_reg   <= CHG_W'(bot_amp_reg) * CHG_W'(eps_reg);
            fb_q_reg    <= (START_W'(top_reg) + START_W'(bottom_reg)) * START_W'(eps_reg);
        end

        if (cmd.fin)
        begin
            out_col_reg  <= prev_col_reg;
            out_addr_reg <= prev_addr_reg;
            start_reg    <= start_next;
            status_reg   <= status_next;
            nf_reg       <= no_full_reg;
            nz_reg       <= no_zero_reg;
            pt_reg       <= POINT_W'(count_reg);
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_column           = out_col_reg;
    assign out_address          = out_addr_reg;
    assign start_half_electrons = start_reg;
    assign pixel_status         = status_reg;
    assign full_not_reached     = nf_reg;
    assign zero_not_seen        = nz_reg;
    assign point_total          = pt_reg;

endmodule

`default_nettype wire

@@ sim/sese_checker.sv @@
`timescale 1ns / 100ps
// result checker for the s-curve edge start estimator: tracks register writes and accepted
// point requests, predicts each finished pixel and compares it with the result channel
// depends on sese_pkg

module sese_checker
    import sese_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 operation,
    input  wire logic [COL_W-1:0]     pixel_column,
    input  wire logic [ADR_W-1:0]     pixel_address,
    input  wire logic [AMP_W-1:0]     amplitude,
    input  wire logic [HIT_W-1:0]     hit_count,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [COL_W-1:0]     out_column,
    input  wire logic [ADR_W-1:0]     out_address,
    input  wire logic [START_W-1:0]   start_half_electrons,
    input  wire logic [STATUS_W-1:0]  pixel_status,
    input  wire logic                 full_not_reached,
    input  wire logic                 zero_not_seen,
    input  wire logic [POINT_W-1:0]   point_total,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        waiting,
    output int                        results_seen
);

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ADR_W-1:0]   adr;
        logic [START_W-1:0] start;
        pix_status_t        status;
        logic               no_full;
        logic               no_zero;
        logic [POINT_W-1:0] total;
    } pixel_result_t;

    logic [HIT_W-1:0] curve_hits [MAX_POINTS];
    logic [AMP_W-1:0] curve_amps [MAX_POINTS];
    int unsigned      curve_len;
    logic [COL_W-1:0] last_col;
    logic [ADR_W-1:0] last_adr;
    logic [CFG_W-1:0] reg_eps;
    logic [CFG_W-1:0] reg_inj;
    logic [CFG_W-1:0] reg_top;
    logic [CFG_W-1:0] reg_bottom;
    pixel_result_t    expected_pixels [$];

    function automatic int unsigned charge_of(logic [AMP_W-1:0] amp);
        int unsigned a;
        a = amp;
        return a * reg_eps;
    endfunction

    // scan the stored curve from both ends and queue the pixel's result
    task automatic close_pixel();
        pixel_result_t r;
        int unsigned   n;
        int unsigned   top_q;
        int unsigned   bot_q;
        int unsigned   upper;
        int unsigned   lower;
        int unsigned   run_up;
        int unsigned   run_down;
        int unsigned   h;
        int unsigned   fallback;
        int unsigned   start;
        logic          found;
        n = curve_len;
        top_q = charge_of(curve_amps[n-1]);
        bot_q = charge_of(curve_amps[0]);
        upper = top_q;
        lower = bot_q;
        run_up = curve_hits[n-1];
        run_down = curve_hits[0];
        r.no_full = 1'b1;
        r.no_zero = 1'b1;
        r.status = PIX_NORMAL;
        // downward: first falling step, the running value is tested before each compare
        found = 1'b0;
        for (int i = 2; i <= n && !found; i++)
        begin
            h = curve_hits[n-i];
            if (run_up == reg_inj)
                r.no_full = 1'b0;
            if (run_up > h)
            begin
                upper = charge_of(curve_amps[n-i]);
                found = 1'b1;
            end
            else
                run_up = h;
        end
        found = 1'b0;
        for (int i = 1; i < n && !found; i++)
        begin
            h = curve_hits[i];
            if (run_down == 0)
                r.no_zero = 1'b0;
            if (run_down < h)
            begin
                lower = charge_of(curve_amps[i]);
                found = 1'b1;
            end
            else
                run_down = h;
        end
        // hot beats dead when injection count is zero
        if (upper == top_q || lower == bot_q)
        begin
            if (curve_hits[0] == reg_inj)
                r.status = PIX_HOT;
            else if (curve_hits[0] == 0)
                r.status = PIX_DEAD;
        end
        fallback = reg_top;
        fallback = (fallback + reg_bottom) * reg_eps;
        start = (r.status != PIX_NORMAL) ? fallback : upper + lower;
        r.col = last_col;
        r.adr = last_adr;
        r.start = start[START_W-1:0];
        r.total = n[POINT_W-1:0];
        expected_pixels.push_back(r);
        curve_len = 0;
    endtask

    task automatic take_request();
        if (operation == OP_FLUSH)
        begin
            if (curve_len != 0)
                close_pixel();
        end
        else
        begin
            if (curve_len != 0 && (pixel_column != last_col || pixel_address != last_adr))
                close_pixel();
            last_col = pixel_column;
            last_adr = pixel_address;
            // points past the store depth are dropped
            if (curve_len < MAX_POINTS)
            begin
                curve_hits[curve_len] = hit_count;
                curve_amps[curve_len] = amplitude;
                curve_len++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t seen;
        pixel_result_t want;
        if (!rst_n)
        begin
            curve_len = 0;
            last_col = '0;
            last_adr = '0;
            reg_eps = RST_EPS;
            reg_inj = RST_INJ;
            reg_top = RST_TOP;
            reg_bottom = RST_BOTTOM;
            expected_pixels.delete();
            fail_count = 0;
            waiting = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.col = out_column;
                seen.adr = out_address;
                seen.start = start_half_electrons;
                seen.status = pix_status_t'(pixel_status);
                seen.no_full = full_not_reached;
                seen.no_zero = zero_not_seen;
                seen.total = point_total;
                results_seen++;
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result col %0d adr %0d start %0d points %0d",
                                 $time, seen.col, seen.adr, seen.start, seen.total);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch, expected col %0d adr %0d start %0d st %0d",
                                     $time, want.col, want.adr, want.start, want.status);
                            $display("    full_miss %0b zero_miss %0b points %0d",
                                     want.no_full, want.no_zero, want.total);
                            $display("    got col %0d adr %0d start %0d st %0d",
                                     seen.col, seen.adr, seen.start, seen.status);
                            $display("    full_miss %0b zero_miss %0b points %0d",
                                     seen.no_full, seen.no_zero, seen.total);
                        end
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_EPS:    reg_eps = cfg_data;
                    CFG_INJ:    reg_inj = cfg_data;
                    CFG_TOP:    reg_top = cfg_data;
                    CFG_BOTTOM: reg_bottom = cfg_data;
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall)
                take_request();
            waiting = expected_pixels.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// top of the s-curve edge start estimator testbench: clock, reset, register settings,
// directed and random point requests, output back-pressure and the verdict
// depends on sese_pkg, sese_checker and the scurve_edge_start_estimator rtl

module testbench;
    import sese_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 270;
    localparam int SETTLE       = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 operation = OP_POINT;
    logic [COL_W-1:0]     pixel_column = '0;
    logic [ADR_W-1:0]     pixel_address = '0;
    logic [AMP_W-1:0]     amplitude = '0;
    logic [HIT_W-1:0]     hit_count = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COL_W-1:0]     out_column;
    logic [ADR_W-1:0]     out_address;
    logic [START_W-1:0]   start_half_electrons;
    logic [STATUS_W-1:0]  pixel_status;
    logic                 full_not_reached;
    logic                 zero_not_seen;
    logic [POINT_W-1:0]   point_total;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_EPS;
    logic [CFG_W-1:0]     cfg_data = '0;

    int fail_count;
    int waiting;
    int results_seen;

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_armed = 1'b0;
    int hold_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int cur_inj = RST_INJ;
    logic [COL_W-1:0] pix_col = '0;
    logic [ADR_W-1:0] pix_adr = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    scurve_edge_start_estimator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pixel_column(pixel_column), .pixel_address(pixel_address),
        .amplitude(amplitude), .hit_count(hit_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_column(out_column), .out_address(out_address),
        .start_half_electrons(start_half_electrons), .pixel_status(pixel_status),
        .full_not_reached(full_not_reached), .zero_not_seen(zero_not_seen),
        .point_total(point_total),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sese_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pixel_column(pixel_column), .pixel_address(pixel_address),
        .amplitude(amplitude), .hit_count(hit_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_column(out_column), .out_address(out_address),
        .start_half_electrons(start_half_electrons), .pixel_status(pixel_status),
        .full_not_reached(full_not_reached), .zero_not_seen(zero_not_seen),
        .point_total(point_total),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .waiting(waiting), .results_seen(results_seen)
    );

    // receiver: one long hold-off once armed, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_armed && hold_count < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send(input logic op, input logic [COL_W-1:0] col,
                        input logic [ADR_W-1:0] adr, input logic [AMP_W-1:0] amp,
                        input logic [HIT_W-1:0] hit);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        operation <= op;
        pixel_column <= col;
        pixel_address <= adr;
        amplitude <= amp;
        hit_count <= hit;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // a flush ignores its other fields, so they are random
    task automatic send_flush();
        send(OP_FLUSH, COL_W'($urandom_range(0, 511)), ADR_W'($urandom_range(0, 1023)),
             AMP_W'($urandom_range(0, 255)), HIT_W'($urandom_range(0, 255)));
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] eps, input logic [CFG_W-1:0] inj,
                            input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] bottom);
        cfg_write <= 1'b1;
        cfg_index <= CFG_EPS;
        cfg_data <= eps;
        @(negedge clk);
        cfg_index <= CFG_INJ;
        cfg_data <= inj;
        @(negedge clk);
        cfg_index <= CFG_TOP;
        cfg_data <= top;
        @(negedge clk);
        cfg_index <= CFG_BOTTOM;
        cfg_data <= bottom;
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_inj = inj;
    endtask

    // mostly s-curves rising to the injection count, some hot, dead and noisy ones
    task automatic send_pixel(input int len);
        int base;
        int stride;
        int th;
        int kind;
        int h;
        int a;
        if ($urandom_range(0, 7) != 0)
        begin
            pix_col = COL_W'($urandom_range(0, 511));
            pix_adr = ADR_W'($urandom_range(0, 1023));
        end
        base = $urandom_range(0, 255);
        stride = $urandom_range(1, 3);
        th = $urandom_range(0, len);
        kind = $urandom_range(0, 9);
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0: h = $urandom_range(0, 255);
                1: h = cur_inj;
                2: h = 0;
                default:
                begin
                    if (i < th)
                        h = 0;
                    else if (i > th)
                        h = cur_inj;
                    else
                        h = $urandom_range(0, cur_inj);
                    if ($urandom_range(0, 19) == 0)
                        h = $urandom_range(0, 255);
                end
            endcase
            a = (kind == 0) ? $urandom_range(0, 255) : (base + i * stride) % 256;
            send(OP_POINT, pix_col, pix_adr, a[AMP_W-1:0], h[HIT_W-1:0]);
        end
        if ($urandom_range(0, 3) == 0)
            send_flush();
    endtask

    initial
    begin
        int start_items;
        int len;
        bit long_done;
        long_done = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset register values
        send_flush();
        send(OP_POINT, 0, 0, 0, 0);
        send_flush();
        send(OP_POINT, 511, 1023, 255, 255);
        send(OP_POINT, 1, 2, 10, 0);
        send(OP_POINT, 1, 2, 11, 0);
        send(OP_POINT, 1, 2, 12, 20);
        send(OP_POINT, 1, 2, 13, 50);
        send(OP_POINT, 1, 2, 14, 50);
        send(OP_POINT, 3, 4, 20, 50);
        send(OP_POINT, 3, 4, 21, 50);
        send(OP_POINT, 3, 4, 22, 50);
        send(OP_POINT, 5, 6, 30, 0);
        send(OP_POINT, 5, 6, 31, 0);
        send(OP_POINT, 5, 6, 32, 0);
        send(OP_POINT, 6, 7, 40, 30);
        send(OP_POINT, 6, 7, 41, 10);
        send(OP_POINT, 6, 7, 42, 60);
        send_flush();
        send_flush();
        send(OP_POINT, 510, 1, 255, 255);
        send(OP_POINT, 510, 1, 0, 0);
        send(OP_POINT, 510, 1, 128, 255);
        send_flush();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1: set_regs(1, 1, 0, 0);
                2: set_regs(255, 255, 255, 255);
                3: set_regs(RST_EPS, RST_INJ, RST_TOP, RST_BOTTOM);
                4: set_regs(CFG_W'($urandom_range(1, 255)), CFG_W'($urandom_range(1, 255)),
                            CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)));
                5: set_regs(0, 0, 255, 0);
                default: ;
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            if (phase == 0)
                hold_armed = 1'b1;
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS)
            begin
                // one pixel overruns the store
                if (!long_done)
                    len = 258;
                else if ($urandom_range(0, 39) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                long_done = 1'b1;
                send_pixel(len);
            end
            send_flush();
            in_valid <= 1'b0;
            while (waiting != 0)
                @(negedge clk);
            repeat (SETTLE) @(negedge clk);
        end

        $display("%0d point and flush requests over %0d register settings and 4 idle patterns,",
                 items_sent, PHASES);
        $display("%0d pixel results compared, %0d still outstanding", results_seen, waiting);
        if (fail_count == 0 && waiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sese_pkg.sv
hw/rtl/sese_ram.sv
hw/rtl/sese_ctrl.sv
hw/rtl/sese_datapath.sv
hw/rtl/scurve_edge_start_estimator.sv
sim/sese_checker.sv
sim/testbench.sv
